/* sv/equidistributed_prng64_macros.svh */
// Assertion macros for the random number generator block.
// Included by the top level; no other dependencies.
`ifndef EQUIDISTRIBUTED_PRNG64_MACROS_SVH
`define EQUIDISTRIBUTED_PRNG64_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset.
`define EQP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while in reset.
`define EQP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EQP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define EQP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* sv/eqprng_pkg.sv */
// Shared types and constants of the 64-bit equidistributed generator.
// No dependencies; used by the seed unit, top level and checker.
package eqprng_pkg;

    // Geometry of the recurrence.
    localparam int          NUM_WORDS = 66;
    localparam logic [6:0]  WORDS_CNT = 7'd66;
    localparam int          MID_LAG   = 29;
    localparam int          TEMP_LAG  = 9;

    // Recurrence and tempering constants.
    localparam logic [63:0] RECUR_XOR  = 64'hfac1e8c56471d722;
    localparam logic [63:0] MASK1      = 64'hcb67b0c18fe14f4d;
    localparam logic [63:0] UPPER_MASK = 64'hfffffff800000000;
    localparam logic [63:0] LOWER_MASK = 64'h00000007ffffffff;

    // Seeding multiplier, split into 32-bit halves.
    localparam logic [31:0] SEED_MULT_LO = 32'h4c957f2d;
    localparam logic [31:0] SEED_MULT_HI = 32'h5851f42d;

    // Seeding sequencer states.
    typedef enum logic [1:0] {
        SD_IDLE,
        SD_MUL,
        SD_ADD
    } seed_state_t;

    // Words handed from the seeding unit to the cell chain.
    typedef struct packed {
        logic        push;
        logic        lung_load;
        logic [63:0] word;
    } seed_push_t;

endpackage

/* sv/eqprng_cell.sv */
// One cell of the state chain: holds a single 64-bit state word.
// Depends on nothing; instantiated by the top level.
module eqprng_cell
(
    input  logic        clk,
    input  logic        shift_en,
    input  logic [63:0] d,
    output logic [63:0] q
);

    logic [63:0] word_reg;
    logic [63:0] word_next;

    // Take the neighbour's word when the chain advances, otherwise hold.
    always_comb
    begin
        word_next = shift_en ? d : word_reg;
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign q = word_reg;

endmodule

/* sv/eqprng_seed.sv */
// Seeding unit: produces the 66 state words and the lung word from a seed.
// Depends on eqprng_pkg; instantiated by the top level.
module eqprng_seed
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     begin_req,
    input  logic [63:0]              seed,
    output logic                     busy,
    output eqprng_pkg::seed_push_t   push
);

    eqprng_pkg::seed_state_t state_reg;
    eqprng_pkg::seed_state_t state_next;
    logic [6:0]  k_reg;
    logic [6:0]  k_next;
    logic [63:0] w_reg;
    logic [63:0] w_next;
    logic [63:0] plo_reg;
    logic [31:0] phl_reg;
    logic [31:0] plh_reg;
    logic [63:0] t_word;
    logic [63:0] plo_next;
    logic [63:0] phl_full;
    logic [63:0] plh_full;
    logic [31:0] cross_sum;
    logic [63:0] sum_word;

    // Partial products of the low 64 bits of the 64x64 multiplication.
    always_comb
    begin
        t_word    = w_reg ^ (w_reg >> 62);
        plo_next  = t_word[31:0]  * eqprng_pkg::SEED_MULT_LO;
        phl_full  = t_word[63:32] * eqprng_pkg::SEED_MULT_LO;
        plh_full  = t_word[31:0]  * eqprng_pkg::SEED_MULT_HI;
    end

    always_ff @(posedge clk)
    begin
        plo_reg <= plo_next;
        phl_reg <= phl_full[31:0];
        plh_reg <= plh_full[31:0];
    end

    // Recombine the partial products and add the word number.
    always_comb
    begin
        cross_sum = phl_reg + plh_reg;
        sum_word  = plo_reg + {cross_sum, 32'd0} + {57'd0, k_reg};
    end

    // State register and word counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eqprng_pkg::SD_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
    end

    // Sequencer: seed first, then each word via the MUL and ADD states.
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        w_next         = w_reg;
        push.push      = 1'b0;
        push.lung_load = 1'b0;
        push.word      = sum_word;
        unique case (state_reg)
            eqprng_pkg::SD_IDLE:
            begin
                if (begin_req)
                begin
                    w_next     = seed;
                    k_next     = 7'd1;
                    push.push  = 1'b1;
                    push.word  = seed;
                    state_next = eqprng_pkg::SD_MUL;
                end
            end
            eqprng_pkg::SD_MUL:
            begin
                state_next = eqprng_pkg::SD_ADD;
            end
            eqprng_pkg::SD_ADD:
            begin
                w_next = sum_word;
                if (k_reg == eqprng_pkg::WORDS_CNT)
                begin
                    push.lung_load = 1'b1;
                    state_next     = eqprng_pkg::SD_IDLE;
                end
                else
                begin
                    push.push  = 1'b1;
                    k_next     = k_reg + 7'd1;
                    state_next = eqprng_pkg::SD_MUL;
                end
            end
            default:
            begin
                state_next = eqprng_pkg::SD_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != eqprng_pkg::SD_IDLE);

endmodule

/* sv/equidistributed_prng64.sv */
// Generate: result strobed on valid the cycle after accept; one word per cycle unless busy.
// The state sits in a rotating chain of 66 cells, so every step reads fixed taps.
// Seed request: busy while each word goes through the split seed multiplier.
// The receiver cannot stall; results are never held back.
// Reset clears the sequencer, the lung word and the strobe; state words stay unknown.
// Depends on eqprng_pkg, eqprng_cell, eqprng_seed and the assertion macro header.
`include "equidistributed_prng64_macros.svh"
module equidistributed_prng64
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [63:0] seed,
    output logic        valid,
    output logic [63:0] value
);

    logic [63:0] cell_q [eqprng_pkg::NUM_WORDS];
    logic [63:0] tail_word;
    logic        shift_en;
    logic        gen_accept;
    logic        seed_accept;
    logic        seed_busy;
    eqprng_pkg::seed_push_t seed_push;
    logic [63:0] lung_reg;
    logic [63:0] lung_next;
    logic [63:0] x_word;
    logic [63:0] s_new;
    logic [63:0] y_word;
    logic        valid_reg;
    logic [63:0] value_reg;

    // Request decode.
    assign busy        = seed_busy;
    assign gen_accept  = start && !seed_busy && !func;
    assign seed_accept = start && !seed_busy && func;

    eqprng_seed u_seed
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .begin_req (seed_accept),
        .seed      (seed),
        .busy      (seed_busy),
        .push      (seed_push)
    );

    // Recurrence step on the taps of the chain; cell 0 always holds s[i].
    always_comb
    begin
        x_word = (cell_q[0] & eqprng_pkg::UPPER_MASK)
               | (cell_q[1] & eqprng_pkg::LOWER_MASK);
        lung_next = (x_word >> 1)
                  ^ (x_word[0] ? eqprng_pkg::RECUR_XOR : 64'd0)
                  ^ cell_q[eqprng_pkg::MID_LAG]
                  ^ lung_reg ^ (lung_reg << 30);
        s_new  = x_word ^ lung_next ^ (lung_next >> 20);
        y_word = s_new ^ (s_new << 5)
               ^ (cell_q[eqprng_pkg::TEMP_LAG] & eqprng_pkg::MASK1);
    end

    // The chain advances on each generate step and on each seed word.
    assign shift_en  = gen_accept || seed_push.push;
    assign tail_word = gen_accept ? s_new : seed_push.word;

    for (genvar c = 0; c < eqprng_pkg::NUM_WORDS; c++)
    begin : g_cell
        if (c == eqprng_pkg::NUM_WORDS - 1)
        begin : g_tail
            eqprng_cell u_cell
            (
                .clk      (clk),
                .shift_en (shift_en),
                .d        (tail_word),
                .q        (cell_q[c])
            );
        end
        else
        begin : g_body
            eqprng_cell u_cell
            (
                .clk      (clk),
                .shift_en (shift_en),
                .d        (cell_q[c + 1]),
                .q        (cell_q[c])
            );
        end
    end

    // Lung word and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lung_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= gen_accept;
            if (gen_accept)
            begin
                lung_reg <= lung_next;
            end
            else if (seed_push.lung_load)
            begin
                lung_reg <= seed_push.word;
            end
        end
    end

    // Result word.
    always_ff @(posedge clk)
    begin
        if (gen_accept)
        begin
            value_reg <= y_word;
        end
    end

    assign valid = valid_reg;
    assign value = value_reg;

    // Checks on the request sequencing.
    `EQP_ASSERT_NXT(a_gen_strobe, clk, rst_n, gen_accept, valid, "generate request gave no result")
    `EQP_ASSERT_NXT(a_seed_busy, clk, rst_n, seed_accept, busy && !valid, "seed request not busy")
    `EQP_ASSERT_IMP(a_no_push_gen, clk, rst_n, seed_push.push, !gen_accept, "seed push during generate")

endmodule

/* tb/equidistributed_prng64_check.sv */
// Checker for the 64-bit equidistributed generator: watches requests and results,
// predicts each generated word and compares it with what the block strobes out.
// Depends on eqprng_pkg for the recurrence geometry and constants.
module equidistributed_prng64_check
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        func,
    input  logic [63:0] seed,
    input  logic        valid,
    input  logic [63:0] value,
    output int          errors,
    output int          pending
);

    localparam logic [63:0] SEED_MULTIPLIER = {eqprng_pkg::SEED_MULT_HI,
                                               eqprng_pkg::SEED_MULT_LO};

    // Predicted generator state.
    logic [63:0] words [eqprng_pkg::NUM_WORDS];
    logic [63:0] lung;
    int unsigned pos;

    // Words the block still owes, oldest first.
    logic [63:0] owed_words [$];
    int          mismatches;

    assign errors = mismatches;

    // One term of the seeding chain.
    function automatic logic [63:0] seed_term(input logic [63:0] w, input int unsigned k);
        return (SEED_MULTIPLIER * (w ^ (w >> 62))) + 64'(k);
    endfunction

    // Fill every state word and the lung from one seed word.
    task automatic reseed_words(input logic [63:0] s);
        words[0] = s;
        for (int unsigned k = 1; k < eqprng_pkg::NUM_WORDS; k++)
        begin
            words[k] = seed_term(words[k - 1], k);
        end
        lung = seed_term(words[eqprng_pkg::NUM_WORDS - 1], eqprng_pkg::NUM_WORDS);
        pos  = 0;
    endtask

    // Advance the recurrence by one step and return the tempered word.
    task automatic next_word(output logic [63:0] y);
        logic [63:0] x;
        x = (words[pos] & eqprng_pkg::UPPER_MASK)
          | (words[(pos + 1) % eqprng_pkg::NUM_WORDS] & eqprng_pkg::LOWER_MASK);
        lung = (x >> 1) ^ (x[0] ? eqprng_pkg::RECUR_XOR : 64'd0)
             ^ words[(pos + eqprng_pkg::MID_LAG) % eqprng_pkg::NUM_WORDS]
             ^ lung ^ (lung << 30);
        words[pos] = x ^ lung ^ (lung >> 20);
        y = words[pos] ^ (words[pos] << 5)
          ^ (words[(pos + eqprng_pkg::TEMP_LAG) % eqprng_pkg::NUM_WORDS] & eqprng_pkg::MASK1);
        pos = (pos + 1) % eqprng_pkg::NUM_WORDS;
    endtask

    initial
    begin
        mismatches = 0;
        pending    = 0;
        lung       = '0;
        pos        = 0;
    end

    // Results are checked before the request of the same edge is predicted.
    always @(posedge clk)
    begin
        logic [63:0] predicted;
        logic [63:0] owed;
        if (!rst_n)
        begin
            owed_words.delete();
            lung = '0;
            pos  = 0;
        end
        else
        begin
            if (valid)
            begin
                if (owed_words.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result: value %h", value);
                    mismatches++;
                end
                else
                begin
                    owed = owed_words.pop_front();
                    if (value !== owed)
                    begin
                        if (mismatches < 10)
                            $display("value mismatch: expected %h, got %h", owed, value);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                if (func)
                    reseed_words(seed);
                else
                begin
                    next_word(predicted);
                    owed_words.push_back(predicted);
                end
            end
        end
        pending <= owed_words.size();
    end

endmodule

/* tb/equidistributed_prng64_test.sv */
// Top of the generator testbench: clock, reset, request stimulus and the verdict.
// Depends on the block, its package and the checker module beside it.
module equidistributed_prng64_test;

    localparam int IDLE_LIMIT   = 1000;
    localparam int RANDOM_ITEMS = 530;
    localparam int CALM_ITEMS   = 100;
    localparam int HOLD_ITEM    = 200;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        func;
    logic [63:0] seed;
    logic        valid;
    logic [63:0] value;
    int          errors;
    int          pending;
    int          quiet_cycles;

    equidistributed_prng64 u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .func  (func),
        .seed  (seed),
        .valid (valid),
        .value (value)
    );

    equidistributed_prng64_check u_check
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .func    (func),
        .seed    (seed),
        .valid   (valid),
        .value   (value),
        .errors  (errors),
        .pending (pending)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on cycles in which neither a request nor a result moves.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || valid)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Present one request and hold it until the block takes it.
    task automatic issue(input logic f, input logic [63:0] s);
        start <= 1'b1;
        func  <= f;
        seed  <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drop the request line for a number of cycles.
    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // A generate request with a random, ignored seed field.
    task automatic generate_word();
        issue(1'b0, {$urandom, $urandom});
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        func         = 1'b0;
        seed         = '0;
        quiet_cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: extreme seeds, seed field ignored while generating,
        // the top seed bits that feed the chain shift, back-to-back seeds.
        issue(1'b1, 64'h0);
        repeat (3) issue(1'b0, 64'hffff_ffff_ffff_ffff);
        issue(1'b1, 64'hffff_ffff_ffff_ffff);
        repeat (3) issue(1'b0, 64'h0);
        issue(1'b1, 64'h1);
        repeat (2) generate_word();
        issue(1'b1, 64'h8000_0000_0000_0000);
        repeat (2) generate_word();
        issue(1'b1, 64'hc000_0000_0000_0000);
        generate_word();
        issue(1'b1, 64'h5555_5555_5555_5555);
        issue(1'b1, 64'haaaa_aaaa_aaaa_aaaa);
        repeat (2) generate_word();

        // Random part: long generate runs that wrap the word index, rare reseeds.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == HOLD_ITEM)
            begin
                pause(1);
                while (pending != 0)
                    @(posedge clk);
            end
            else if (n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(3) == 0)
                pause($urandom_range(8, 1));
            if ($urandom_range(79) == 0)
                issue(1'b1, {$urandom, $urandom});
            else
                generate_word();
        end
        start <= 1'b0;

        // Drain the outstanding words, then give the verdict.
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/eqprng_pkg.sv
sv/eqprng_cell.sv
sv/eqprng_seed.sv
sv/equidistributed_prng64.sv
tb/equidistributed_prng64_check.sv
tb/equidistributed_prng64_test.sv
